@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
// No dependencies; every use expects signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Consequence expected in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/qgps_pkg.sv @@
// Types and constants for the quadtree grid patch split block.
// No dependencies; imported by every module of the block.
package qgps_pkg;

    localparam int INDEX_BITS    = 22;
    localparam int RW_BITS       = 12;
    localparam int DEPTH_BITS    = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int RQ_BITS       = RW_BITS + INDEX_BITS;
    localparam int EXP_BITS      = $clog2(INDEX_BITS);

    localparam logic [RW_BITS-1:0]    ROW_WIDTH_RST = 12'd257;
    localparam logic [DEPTH_BITS-1:0] MAX_DEPTH_RST = 4'd4;

    typedef logic [INDEX_BITS-1:0] idx_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROW_WIDTH = 2'd0,
        CFG_MAX_DEPTH = 2'd1
    } cfg_reg_e;

    typedef struct packed {
        idx_t                  corner_lt;
        idx_t                  corner_rt;
        idx_t                  corner_lb;
        idx_t                  corner_rb;
        logic [DEPTH_BITS-1:0] node_depth;
    } in_word_t;

    typedef struct packed {
        logic is_leaf;
        idx_t top_mid;
        idx_t right_mid;
        idx_t bottom_mid;
        idx_t left_mid;
        idx_t center;
    } out_word_t;

    // One divider lane: remainder in the upper bits, dividend shifting out
    // and quotient shifting in at the bottom.
    typedef struct packed {
        logic               is_leaf;
        idx_t               lt;
        idx_t               rt;
        idx_t               lb;
        idx_t               span_x;
        logic [RQ_BITS-1:0] rq;
    } div_lane_t;

    typedef struct packed {
        logic is_leaf;
        idx_t lt;
        idx_t rt;
        idx_t lb;
        idx_t ws;
        idx_t vstep;
    } split_word_t;

endpackage

@@ design/quadtree_grid_patch_split_top.sv @@
// Top level of the quadtree grid patch split block.
// Depends on qgps_pkg, qgps_div_cell, qgps_split and assert_macros.svh.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------
//  in      | in_valid / in_ready     | in_data   (qgps_pkg::in_word_t)
//  out     | out_valid / out_ready   | out_data  (qgps_pkg::out_word_t)
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One word per cycle while the skid is empty; the path runs through the entry
// register, one divider cell per quotient bit, split stage, output register.
// The row-width division is a chain of 22 restoring cells, one bit each.
// rst_n clears valid bits and loads row_width = 257, max_depth = 4.
// A two-entry output buffer (output register plus skid) decouples the
// sides; in_ready drops only once the skid holds a word, and the whole
// chain freezes until out_ready drains it. cfg_ready is always high.
`include "assert_macros.svh"

module quadtree_grid_patch_split_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  qgps_pkg::in_word_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output qgps_pkg::out_word_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qgps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [qgps_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import qgps_pkg::*;

    // configuration registers
    logic [RW_BITS-1:0]    row_width_reg;
    logic [DEPTH_BITS-1:0] max_depth_reg;

    // pipeline enable: whole chain advances unless the skid is occupied
    logic en;

    // entry stage
    logic      entry_valid_reg;
    div_lane_t entry_lane_reg;
    div_lane_t entry_lane_next;

    // divider chain
    logic [INDEX_BITS:0] chain_valid;
    div_lane_t           chain_lane [0:INDEX_BITS];

    // split stage
    logic        split_valid;
    split_word_t split_word;

    // output buffer
    out_word_t result;
    logic      pop;
    logic      push;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_word_t skid_word_reg;

    // all index fields of the presented word are zero
    logic      out_idx_zero;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RST;
            max_depth_reg <= MAX_DEPTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_ROW_WIDTH: row_width_reg <= cfg_data[RW_BITS-1:0];
                CFG_MAX_DEPTH: max_depth_reg <= cfg_data[DEPTH_BITS-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // ---------------- entry stage ----------------
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    always_comb
    begin
        entry_lane_next.is_leaf = (in_data.node_depth >= max_depth_reg);
        entry_lane_next.lt      = in_data.corner_lt;
        entry_lane_next.rt      = in_data.corner_rt;
        entry_lane_next.lb      = in_data.corner_lb;
        entry_lane_next.span_x  = in_data.corner_rt - in_data.corner_lt;
        entry_lane_next.rq      = {{RW_BITS{1'b0}}, in_data.corner_lb - in_data.corner_lt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            entry_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_lane_reg <= entry_lane_next;
        end
    end

    // ---------------- divider chain: vertical span / row_width ----------------
    assign chain_valid[0] = entry_valid_reg;
    assign chain_lane[0]  = entry_lane_reg;

    for (genvar g = 0; g < INDEX_BITS; g++)
    begin : g_cell
        qgps_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (row_width_reg),
            .in_valid  (chain_valid[g]),
            .in_lane   (chain_lane[g]),
            .out_valid (chain_valid[g+1]),
            .out_lane  (chain_lane[g+1])
        );
    end

    // ---------------- split sizes ----------------
    qgps_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .row_width (row_width_reg),
        .in_valid  (chain_valid[INDEX_BITS]),
        .in_lane   (chain_lane[INDEX_BITS]),
        .out_valid (split_valid),
        .out_word  (split_word)
    );

    // midpoints; a leaf gives all-zero indices
    always_comb
    begin
        result.is_leaf = split_word.is_leaf;
        if (split_word.is_leaf)
        begin
            result.top_mid    = '0;
            result.right_mid  = '0;
            result.bottom_mid = '0;
            result.left_mid   = '0;
            result.center     = '0;
        end
        else
        begin
            result.top_mid    = split_word.lt + split_word.ws;
            result.right_mid  = split_word.rt + split_word.vstep;
            result.bottom_mid = split_word.lb + split_word.ws;
            result.left_mid   = split_word.lt + split_word.vstep;
            result.center     = split_word.lt + split_word.ws + split_word.vstep;
        end
    end

    // ---------------- output register and skid ----------------
    assign pop  = out_valid_reg && out_ready;
    assign push = en && split_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_word_reg <= skid_word_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_word_reg <= result;
            end
            else
            begin
                skid_word_reg <= result;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // ---------------- checks ----------------
    assign out_idx_zero = (out_data.top_mid == '0) && (out_data.right_mid == '0)
                       && (out_data.bottom_mid == '0) && (out_data.left_mid == '0)
                       && (out_data.center == '0);

    `ASSERT_IMPLIES(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `ASSERT_NEXT(a_stall_cause, out_valid && !out_ready && split_valid && en, !in_ready)
    `ASSERT_IMPLIES(a_leaf_zero, out_valid && out_data.is_leaf, out_idx_zero)

endmodule

@@ design/qgps_div_cell.sv @@
// One restoring-divider cell: produces one quotient bit per word.
// Depends on qgps_pkg.
module qgps_div_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [qgps_pkg::RW_BITS-1:0] divisor,
    input  logic                      in_valid,
    input  qgps_pkg::div_lane_t       in_lane,
    output logic                      out_valid,
    output qgps_pkg::div_lane_t       out_lane
);
    import qgps_pkg::*;

    logic [RW_BITS:0] trial;
    logic [RW_BITS:0] diff;
    logic             fits;
    div_lane_t        lane_next;
    logic             valid_reg;
    div_lane_t        lane_reg;

    always_comb
    begin
        trial     = {in_lane.rq[RQ_BITS-1 -: RW_BITS], in_lane.rq[INDEX_BITS-1]};
        fits      = (trial >= {1'b0, divisor});
        diff      = trial - {1'b0, divisor};
        lane_next = in_lane;
        if (fits)
        begin
            lane_next.rq = {diff[RW_BITS-1:0], in_lane.rq[INDEX_BITS-2:0], 1'b1};
        end
        else
        begin
            lane_next.rq = {trial[RW_BITS-1:0], in_lane.rq[INDEX_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

@@ design/qgps_split.sv @@
// Split-size stage: rounds both spans to powers of two, forms the row step.
// Depends on qgps_pkg.
module qgps_split (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [qgps_pkg::RW_BITS-1:0] row_width,
    input  logic                         in_valid,
    input  qgps_pkg::div_lane_t          in_lane,
    output logic                         out_valid,
    output qgps_pkg::split_word_t        out_word
);
    import qgps_pkg::*;

    // {nonzero, exponent} of the split size of s
    function automatic logic [EXP_BITS:0] split_code(input idx_t s);
        idx_t                  h;
        logic [EXP_BITS-1:0]   k;
        logic [INDEX_BITS+1:0] m1;
        logic [INDEX_BITS+1:0] m3;
        logic [INDEX_BITS+1:0] s2;
        logic [EXP_BITS-1:0]   e;
        h = s >> 1;
        k = '0;
        for (int i = 0; i < INDEX_BITS; i++)
        begin
            if (h[i])
            begin
                k = EXP_BITS'(i + 1);
            end
        end
        m1 = (INDEX_BITS+2)'(1) << k;
        m3 = m1 + (m1 << 1);
        s2 = {1'b0, s, 1'b0};
        e  = (s2 <= m3) ? k - EXP_BITS'(1) : k;
        return {(h != '0), e};
    endfunction

    idx_t                       quot;
    logic [EXP_BITS:0]          code_x;
    logic [EXP_BITS:0]          code_z;
    logic [INDEX_BITS+RW_BITS-1:0] row_shift;
    split_word_t                word_next;
    logic                       valid_reg;
    split_word_t                word_reg;

    always_comb
    begin
        quot      = (row_width == '0) ? '0 : in_lane.rq[INDEX_BITS-1:0];
        code_x    = split_code(in_lane.span_x);
        code_z    = split_code(quot);
        row_shift = (INDEX_BITS+RW_BITS)'(row_width) << code_z[EXP_BITS-1:0];
        word_next.is_leaf = in_lane.is_leaf;
        word_next.lt      = in_lane.lt;
        word_next.rt      = in_lane.rt;
        word_next.lb      = in_lane.lb;
        word_next.ws      = code_x[EXP_BITS] ? (idx_t'(1) << code_x[EXP_BITS-1:0]) : '0;
        word_next.vstep   = code_z[EXP_BITS] ? row_shift[INDEX_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
